// ===== rtl/pcidq_pkg.sv =====
// Package for the per-CPU interrupt dispatch queue.
// Holds field widths, action, operation and result codes, and the classified operation type.
// No dependencies.
package pcidq_pkg;

	// field widths
	localparam int ACTION_W = 2;
	localparam int IRQ_W    = 5;
	localparam int KIND_W   = 3;
	localparam int MASK_W   = 32;
	localparam int LIMIT_W  = 4;
	localparam int ENTRY_W  = IRQ_W + 1;

	// input actions
	localparam logic [ACTION_W-1:0] ACT_PROC = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_IMM  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DONE = 2'd2;

	// classified operations passed from front to back
	localparam logic [1:0] OP_DROP = 2'd0;
	localparam logic [1:0] OP_PROC = 2'd1;
	localparam logic [1:0] OP_IMM  = 2'd2;
	localparam logic [1:0] OP_DONE = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] K_DISPATCH = 3'd0;
	localparam logic [KIND_W-1:0] K_RUN      = 3'd1;
	localparam logic [KIND_W-1:0] K_RESUME   = 3'd2;
	localparam logic [KIND_W-1:0] K_QUEUED   = 3'd3;
	localparam logic [KIND_W-1:0] K_DROPPED  = 3'd4;

	// configuration register indexes
	localparam logic REG_MASK  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]       op;
		logic             cpu;
		logic [IRQ_W-1:0] irq;
	} op_t;

endpackage

// ===== rtl/pcidq_if.sv =====
// Channel interfaces of the interrupt dispatch queue: event requests in, results out.
// Depends on pcidq_pkg for field widths.
interface pcidq_req_if;
	logic                           valid;
	logic                           ready;
	logic [pcidq_pkg::ACTION_W-1:0] action;
	logic                           cpu_index;
	logic [pcidq_pkg::IRQ_W-1:0]    irq_number;

	modport source (output valid, action, cpu_index, irq_number, input ready);
	modport sink (input valid, action, cpu_index, irq_number, output ready);
endinterface

interface pcidq_res_if;
	logic                         valid;
	logic                         ready;
	logic [pcidq_pkg::KIND_W-1:0] result_kind;
	logic                         result_cpu;
	logic [pcidq_pkg::IRQ_W-1:0]  result_irq;
	logic                         last_result;

	modport source (output valid, result_kind, result_cpu, result_irq, last_result,
		input ready);
	modport sink (input valid, result_kind, result_cpu, result_irq, last_result,
		output ready);
endinterface

// ===== rtl/pcidq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcidq_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/pcidq_front.sv =====
// Front end: accepts request beats, classifies them and holds them in a two-entry queue.
// Depends on pcidq_pkg and pcidq_if.
module pcidq_front #(
	parameter int NUM_IRQS = 32,
	parameter int NUM_CPUS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pcidq_req_if.sink                  req,
	input  logic [pcidq_pkg::MASK_W-1:0] irq_mask,
	output logic                       op_valid,
	output pcidq_pkg::op_t             op,
	input  logic                       op_take
);
	import pcidq_pkg::*;

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	op_t        cls;
	logic       cls_keep;
	logic       push;
	logic       out_of_range;
	logic       cpu_eff;

	assign req.ready = (fill_q != 2'd2);
	assign push      = req.valid && req.ready && cls_keep;

	// classify the incoming beat
	always_comb begin
		out_of_range = ({2'b00, req.irq_number} >= 7'(NUM_IRQS));
		cpu_eff      = (NUM_CPUS > 1) ? req.cpu_index : 1'b0;
		cls.cpu      = cpu_eff;
		cls.irq      = req.irq_number;
		cls.op       = OP_DROP;
		cls_keep     = 1'b1;
		case (req.action)
			ACT_PROC: begin
				if (out_of_range || irq_mask[req.irq_number]) begin
					cls.op = OP_DROP;
				end else begin
					cls.op = OP_PROC;
				end
			end
			ACT_IMM: begin
				cls.cpu = 1'b0;
				cls.op  = out_of_range ? OP_DROP : OP_IMM;
			end
			ACT_DONE: begin
				cls.op = OP_DONE;
			end
			default: begin
				// unused action code: no results
				cls_keep = 1'b0;
			end
		endcase
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !op_take) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && op_take) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	assign op_valid = (fill_q != 2'd0);
	assign op       = slot_q[rd_ptr_q];
endmodule

// ===== rtl/pcidq_back.sv =====
// Back end: per-CPU busy state, pending FIFOs in RAM, completion chains and the result register.
// Depends on pcidq_pkg, pcidq_if and pcidq_ram.
module pcidq_back #(
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_CPUS    = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	input  pcidq_pkg::op_t                op,
	output logic                          op_take,
	input  logic [pcidq_pkg::LIMIT_W-1:0] queue_limit,
	pcidq_res_if.source                   res
);
	import pcidq_pkg::*;

	localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int ENTRIES = NUM_CPUS * QUEUE_DEPTH;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0]        state_q, state_d;
	logic              cur_cpu_q;
	logic              busy_q  [NUM_CPUS];
	logic [HEAD_W-1:0] head_q  [NUM_CPUS];
	logic [CNT_W-1:0]  count_q [NUM_CPUS];

	logic              res_valid_q;
	logic [KIND_W-1:0] res_kind_q;
	logic              res_cpu_q;
	logic [IRQ_W-1:0]  res_irq_q;
	logic              res_last_q;

	logic              cpu_sel;
	logic [CPU_W-1:0]  ci;
	logic              out_free;
	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [IRQ_W-1:0]  e_irq;
	logic              e_last;
	logic              set_busy, clr_busy, push, pop;
	logic              can_queue;
	logic [SUM_W-1:0]  tail_sum;
	logic [HEAD_W-1:0] tail;
	logic [HEAD_W-1:0] head_inc;
	logic [HEAD_W-1:0] head_rd;
	logic [AW-1:0]     base;
	logic [AW-1:0]     waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;

	// current CPU and its FIFO pointers
	always_comb begin
		cpu_sel   = (state_q == S_IDLE) ? op.cpu : cur_cpu_q;
		ci        = CPU_W'(cpu_sel);
		out_free  = !res_valid_q || res.ready;
		can_queue = (8'(count_q[ci]) < 8'(queue_limit)) &&
			(8'(count_q[ci]) < 8'(QUEUE_DEPTH));
		tail_sum  = SUM_W'(head_q[ci]) + SUM_W'(count_q[ci]);
		tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
			HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
		head_inc  = (head_q[ci] == HEAD_W'(QUEUE_DEPTH - 1)) ?
			'0 : head_q[ci] + HEAD_W'(1);
		base      = AW'(ci) * AW'(QUEUE_DEPTH);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		op_take  = 1'b0;
		emit     = 1'b0;
		e_kind   = K_DROPPED;
		e_irq    = op.irq;
		e_last   = 1'b1;
		set_busy = 1'b0;
		clr_busy = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (op_valid && out_free) begin
					op_take = 1'b1;
					case (op.op)
						OP_DROP: begin
							emit   = 1'b1;
							e_kind = K_DROPPED;
						end
						OP_PROC, OP_IMM: begin
							emit = 1'b1;
							if (!busy_q[ci]) begin
								set_busy = 1'b1;
								if (op.op == OP_IMM) begin
									e_kind  = K_RUN;
									e_last  = 1'b0;
									state_d = S_PREP;
								end else begin
									e_kind = K_DISPATCH;
								end
							end else if (can_queue) begin
								push   = 1'b1;
								e_kind = K_QUEUED;
							end else begin
								e_kind = K_DROPPED;
							end
						end
						OP_DONE: begin
							if (!busy_q[ci]) begin
								emit   = 1'b1;
								e_kind = K_RESUME;
								e_irq  = '0;
							end else begin
								state_d = S_PREP;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_PREP: begin
				if (count_q[ci] == '0) begin
					if (out_free) begin
						emit     = 1'b1;
						e_kind   = K_RESUME;
						e_irq    = '0;
						clr_busy = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					// head entry read this cycle, used next cycle
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (out_free) begin
					pop   = 1'b1;
					emit  = 1'b1;
					e_irq = rdata[IRQ_W-1:0];
					if (rdata[ENTRY_W-1]) begin
						e_kind  = K_RUN;
						e_last  = 1'b0;
						state_d = (count_q[ci] == CNT_W'(1)) ? S_PREP : S_POP;
					end else begin
						e_kind  = K_DISPATCH;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// FIFO RAM addressing: read ahead to the next head while popping
	always_comb begin
		head_rd = pop ? head_inc : head_q[ci];
		raddr   = base + AW'(head_rd);
		waddr   = base + AW'(tail);
		wdata   = {op.op == OP_IMM, op.irq};
	end

	pcidq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_fifo_ram (
		.clk  (clk),
		.we   (push),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_cpu_q   <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				busy_q[i]  <= 1'b0;
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (op_take) begin
				cur_cpu_q <= op.cpu;
			end
			if (set_busy) begin
				busy_q[ci] <= 1'b1;
			end else if (clr_busy) begin
				busy_q[ci] <= 1'b0;
			end
			if (push) begin
				count_q[ci] <= count_q[ci] + CNT_W'(1);
			end else if (pop) begin
				count_q[ci] <= count_q[ci] - CNT_W'(1);
				head_q[ci]  <= head_inc;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_kind_q <= e_kind;
			res_cpu_q  <= cpu_sel;
			res_irq_q  <= e_irq;
			res_last_q <= e_last;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.result_kind = res_kind_q;
	assign res.result_cpu  = res_cpu_q;
	assign res.result_irq  = res_irq_q;
	assign res.last_result = res_last_q;
endmodule

// ===== rtl/per_cpu_interrupt_dispatch_queue.sv =====
// Per-CPU interrupt dispatch queue: top level with APB configuration registers.
// A request beat is taken into the front queue, and the back end registers its first result;
// drops, dispatches, queued results and idle completions are handled in the idle state alone.
// A busy completion moves to the prep state, which reads the FIFO RAM head (registered RAM read),
// then the pop state emits each popped entry, and the prep state gives a final resume once empty.
// Reset clears busy flags, FIFO pointers and counts; irq_mask resets to 0, queue_limit to 8.
module per_cpu_interrupt_dispatch_queue #(
	parameter int NUM_IRQS    = 32,
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_CPUS    = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	pcidq_req_if.sink   req,
	pcidq_res_if.source res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcidq_pkg::*;

	logic [MASK_W-1:0]  irq_mask_q;
	logic [LIMIT_W-1:0] queue_limit_q;
	logic               op_valid;
	op_t                op;
	logic               op_take;
	logic               wr_en;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_mask_q    <= '0;
			queue_limit_q <= LIMIT_W'(8);
		end else if (wr_en) begin
			if (paddr[2] == REG_MASK) begin
				irq_mask_q <= pwdata;
			end else begin
				queue_limit_q <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_LIMIT) ? {28'd0, queue_limit_q} : irq_mask_q;

	pcidq_front #(
		.NUM_IRQS(NUM_IRQS),
		.NUM_CPUS(NUM_CPUS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.irq_mask(irq_mask_q),
		.op_valid(op_valid),
		.op      (op),
		.op_take (op_take)
	);

	pcidq_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.NUM_CPUS   (NUM_CPUS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op         (op),
		.op_take    (op_take),
		.queue_limit(queue_limit_q),
		.res        (res)
	);
endmodule

// ===== verif/tb_per_cpu_interrupt_dispatch_queue.sv =====
// Testbench for the per-CPU interrupt dispatch queue: drives event beats and configuration
// writes, predicts every result beat in its own model of the dispatcher and checks them in order.
// Depends on pcidq_pkg, the pcidq_req_if/pcidq_res_if interfaces and the top-level RTL.
module tb_per_cpu_interrupt_dispatch_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import pcidq_pkg::*;

	localparam int CPUS            = 2;
	localparam int DEPTH           = 8;
	localparam int IRQS            = 32;
	localparam int QUIET_CYCLES    = 24;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int MAX_REPORTS     = 40;

	// action code the block must ignore
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              cpu;
		logic [IRQ_W-1:0]  irq;
		logic              is_last;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	bit hold_off_req = 1'b0;
	int mismatches   = 0;

	// dispatcher model: configuration, busy flags and per-CPU pending rings
	logic [MASK_W-1:0]  mask_copy;
	logic [LIMIT_W-1:0] limit_copy;
	logic               cpu_busy [CPUS];
	logic [ENTRY_W-1:0] pend_entry [CPUS][DEPTH];
	int                 pend_head [CPUS];
	int                 pend_count [CPUS];
	outcome_t           outcome_q [$];

	pcidq_req_if req_ch ();
	pcidq_res_if res_ch ();

	per_cpu_interrupt_dispatch_queue #(
		.NUM_IRQS(IRQS),
		.QUEUE_DEPTH(DEPTH),
		.NUM_CPUS(CPUS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_outcome(input logic [KIND_W-1:0] kind, input logic cpu,
		input logic [IRQ_W-1:0] irq);
		outcome_t o;
		o.kind    = kind;
		o.cpu     = cpu;
		o.irq     = irq;
		o.is_last = 1'b0;
		outcome_q = {outcome_q, o};
	endfunction

	// queue behind a busy CPU while under the (saturated) limit, else drop
	function automatic void queue_or_drop(input logic cpu, input logic [IRQ_W-1:0] irq,
		input logic imm);
		int lim;
		lim = (limit_copy > DEPTH) ? DEPTH : limit_copy;
		if (pend_count[cpu] < lim) begin
			pend_entry[cpu][(pend_head[cpu] + pend_count[cpu]) % DEPTH] = {imm, irq};
			pend_count[cpu]++;
			add_outcome(K_QUEUED, cpu, irq);
		end else begin
			add_outcome(K_DROPPED, cpu, irq);
		end
	endfunction

	// pop pending entries: immediate ones run and complete in a chain,
	// a processing one is dispatched, an empty ring resumes the thread
	function automatic void drain_pending(input logic cpu);
		logic [ENTRY_W-1:0] e;
		while (pend_count[cpu] > 0) begin
			e = pend_entry[cpu][pend_head[cpu]];
			pend_head[cpu] = (pend_head[cpu] + 1) % DEPTH;
			pend_count[cpu]--;
			cpu_busy[cpu] = 1'b1;
			if (e[IRQ_W]) begin
				add_outcome(K_RUN, cpu, e[IRQ_W-1:0]);
			end else begin
				add_outcome(K_DISPATCH, cpu, e[IRQ_W-1:0]);
				return;
			end
		end
		cpu_busy[cpu] = 1'b0;
		add_outcome(K_RESUME, cpu, '0);
	endfunction

	// results caused by one accepted event beat
	function automatic void dispatch_outcomes(input logic [ACTION_W-1:0] act, input logic cpu,
		input logic [IRQ_W-1:0] irq);
		int first;
		first = outcome_q.size();
		case (act)
			ACT_PROC: begin
				if (mask_copy[irq]) begin
					add_outcome(K_DROPPED, cpu, irq);
				end else if (!cpu_busy[cpu]) begin
					cpu_busy[cpu] = 1'b1;
					add_outcome(K_DISPATCH, cpu, irq);
				end else begin
					queue_or_drop(cpu, irq, 1'b0);
				end
			end
			ACT_IMM: begin
				// immediate handlers always land on CPU 0 and ignore the mask
				if (!cpu_busy[0]) begin
					cpu_busy[0] = 1'b1;
					add_outcome(K_RUN, 1'b0, irq);
					drain_pending(1'b0);
				end else begin
					queue_or_drop(1'b0, irq, 1'b1);
				end
			end
			ACT_DONE: begin
				if (!cpu_busy[cpu])
					add_outcome(K_RESUME, cpu, '0);
				else
					drain_pending(cpu);
			end
			default: ;
		endcase
		if (outcome_q.size() > first) begin
			outcome_q[outcome_q.size() - 1].is_last = 1'b1;
		end
	endfunction

	// one event beat, with an optional gap in front of it
	task automatic send_event(input logic [ACTION_W-1:0] act, input logic cpu,
		input logic [IRQ_W-1:0] irq);
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.action     = act;
		req_ch.cpu_index  = cpu;
		req_ch.irq_number = irq;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		dispatch_outcomes(act, cpu, irq);
	endtask

	// APB write: setup cycle then access cycle
	task automatic write_reg(input logic index, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {index, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (index == REG_MASK)
			mask_copy = value;
		else
			limit_copy = value[LIMIT_W-1:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// stop offering, let every awaited result arrive, then allow for ignored beats
	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// mostly raises with random targets, completions at the given percentage
	task automatic send_random_events(input int count, input int done_pct);
		int                  sent;
		int                  pick;
		logic [ACTION_W-1:0] act;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < done_pct)
				act = ACT_DONE;
			else if (pick >= 97)
				act = ACT_UNUSED;
			else if ($urandom_range(0, 2) == 0)
				act = ACT_IMM;
			else
				act = ACT_PROC;
			send_event(act, 1'($urandom_range(0, 1)), 5'($urandom_range(0, IRQS - 1)));
			if (act != ACT_UNUSED)
				sent++;
		end
	endtask

	// idle completions, unused code, dispatch, queueing and an immediate chain
	task automatic test_dispatch_and_chain();
		send_event(ACT_DONE, 1'b0, 5'd0);
		send_event(ACT_DONE, 1'b1, 5'd31);
		send_event(ACT_UNUSED, 1'b1, 5'd31);
		send_event(ACT_PROC, 1'b0, 5'd0);
		send_event(ACT_PROC, 1'b1, 5'd31);
		send_event(ACT_PROC, 1'b0, 5'd5);
		send_event(ACT_IMM, 1'b1, 5'd7);
		send_event(ACT_IMM, 1'b0, 5'd9);
		send_event(ACT_DONE, 1'b0, 5'd0);
		send_event(ACT_DONE, 1'b0, 5'd0);
		send_event(ACT_IMM, 1'b0, 5'd31);
		send_event(ACT_DONE, 1'b1, 5'd0);
	endtask

	// masked processing raises drop, immediate ones pass regardless
	task automatic test_mask();
		settle();
		write_reg(REG_MASK, 32'h8000_0001);
		send_event(ACT_PROC, 1'b0, 5'd0);
		send_event(ACT_PROC, 1'b1, 5'd31);
		send_event(ACT_IMM, 1'b1, 5'd0);
		send_event(ACT_PROC, 1'b1, 5'd1);
	endtask

	// a zero limit drops every raise to a busy CPU
	task automatic test_limit_zero();
		settle();
		write_reg(REG_LIMIT, 32'd0);
		send_event(ACT_PROC, 1'b0, 5'd3);
		send_event(ACT_PROC, 1'b0, 5'd4);
		send_event(ACT_IMM, 1'b0, 5'd1);
		send_event(ACT_DONE, 1'b0, 5'd0);
	endtask

	// a limit above the ring depth saturates; the full ring then drains as one chain
	task automatic test_limit_saturation();
		int i;
		settle();
		write_reg(REG_LIMIT, 32'd15);
		write_reg(REG_MASK, 32'd0);
		send_event(ACT_PROC, 1'b0, 5'd10);
		for (i = 0; i < DEPTH + 1; i++)
			send_event(ACT_IMM, 1'b0, 5'(20 + i));
		send_event(ACT_DONE, 1'b0, 5'd0);
	endtask

	task automatic test_random_phases();
		settle();
		write_reg(REG_MASK, 32'd0);
		write_reg(REG_LIMIT, 32'd15);
		send_random_events(25, 15);
		settle();
		write_reg(REG_MASK, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT, 32'd1);
		send_random_events(20, 30);
		settle();
		write_reg(REG_MASK, $urandom & $urandom);
		write_reg(REG_LIMIT, 32'd0);
		send_random_events(20, 30);
		settle();
		write_reg(REG_MASK, $urandom & $urandom & $urandom);
		write_reg(REG_LIMIT, $urandom_range(2, 7));
		send_random_events(25, 25);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		settle();
		write_reg(REG_MASK, 32'd0);
		write_reg(REG_LIMIT, 32'd8);
		src_idle_on  = 1'b0;
		hold_off_req = 1'b1;
		send_random_events(30, 20);
		src_idle_on = 1'b1;
	endtask

	// closing stretch with both sides always ready
	task automatic test_steady_stream();
		settle();
		write_reg(REG_MASK, $urandom & $urandom);
		write_reg(REG_LIMIT, 32'd8);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_random_events(30, 30);
	endtask

	// result receiver: long hold-off on request, else short random stalls
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	// compare each result beat with the oldest awaited one
	always @(posedge clk) begin
		outcome_t seen;
		outcome_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen.kind    = res_ch.result_kind;
			seen.cpu     = res_ch.result_cpu;
			seen.irq     = res_ch.result_irq;
			seen.is_last = res_ch.last_result;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none,", $time,
						" got kind %0d cpu %0d irq %0d last %0b",
						seen.kind, seen.cpu, seen.irq, seen.is_last);
			end else begin
				want = outcome_q.pop_front();
				if (seen.kind !== want.kind || seen.cpu !== want.cpu ||
					seen.irq !== want.irq || seen.is_last !== want.is_last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result mismatch,", $time,
							" expected kind %0d cpu %0d irq %0d last %0b,",
							want.kind, want.cpu, want.irq, want.is_last,
							" got kind %0d cpu %0d irq %0d last %0b",
							seen.kind, seen.cpu, seen.irq, seen.is_last);
				end
			end
		end
	end

	// watchdog: cycles in a row with no beat and no register access
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
				stalled = 0;
			else
				stalled++;
		end
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int c;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_PROC;
		req_ch.cpu_index  = 1'b0;
		req_ch.irq_number = '0;
		mask_copy         = '0;
		limit_copy        = LIMIT_W'(8);
		for (c = 0; c < CPUS; c++) begin
			cpu_busy[c]   = 1'b0;
			pend_head[c]  = 0;
			pend_count[c] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_dispatch_and_chain();
		test_mask();
		test_limit_zero();
		test_limit_saturation();
		test_random_phases();
		test_backpressure();
		test_steady_stream();
		settle();

		if (mismatches == 0 && outcome_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
